// ===== rtl/stable_min_heap_priority_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// stable min-heap priority queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STABLE_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SMHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smhpq_pkg
// shared types and constants of the stable min-heap priority queue
// ----------------------------------------------------------------------------
package smhpq_pkg;

	localparam int unsigned CAPACITY_DEF = 128;

	// one heap slot, id in the low bits
	typedef struct packed {
		logic [63:0] ord;
		logic [31:0] pri;
		logic [31:0] id;
	} entry_t;

endpackage

// ===== rtl/smhpq_cmp.sv =====
// ----------------------------------------------------------------------------
// smhpq_cmp
// shared ordering unit: signed priority first, sequence stamp breaks ties
// ----------------------------------------------------------------------------
module smhpq_cmp import smhpq_pkg::*; (
	input  entry_t a,
	input  entry_t b,
	output logic   a_first
);

	logic pri_lt;
	logic pri_eq;
	logic ord_lt;

	assign pri_lt  = $signed(a.pri) < $signed(b.pri);
	assign pri_eq  = a.pri == b.pri;
	assign ord_lt  = a.ord < b.ord;
	assign a_first = pri_lt || (pri_eq && ord_lt);

endmodule

// ===== rtl/stable_min_heap_priority_queue_top.sv =====
// push: straight to ST_FIN when full or empty, else ST_UP climbs until the parent wins or the root is reached
// pop: straight to ST_FIN when empty or emptied, else ST_DN_LOAD, then ST_DN_PICK and ST_DN_CMP per level sunk
// one item at a time: a new request is taken only in ST_IDLE
// the single compare unit and the one-write, two-read heap memory set the pace
// reset clears count, stamp counter, sequencer and output valid; heap memory is not cleared
// ----------------------------------------------------------------------------
// stable_min_heap_priority_queue_top
// binary min-heap priority queue with fifo order among equal priorities
// ----------------------------------------------------------------------------
module stable_min_heap_priority_queue_top import smhpq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// request side
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // task_id[31:0], priority_req[63:32]
	input  logic [0:0]   s_tuser,   // operation[0]: 0 push, 1 pop
	// result side
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata,   // popped_id[31:0], popped_priority[63:32],
	                                // popped_order[127:64], head_id[159:128],
	                                // head_priority[191:160], count[199:192]
	output logic [1:0]   m_tuser    // ok[0], head_valid[1]
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = AW + 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_UP      = 6'b000010,
		ST_DN_LOAD = 6'b000100,
		ST_DN_PICK = 6'b001000,
		ST_DN_CMP  = 6'b010000,
		ST_FIN     = 6'b100000
	} state_t;

	// heap storage; slot 0 (the root) lives in root_q, memory slot 0 stays unused
	entry_t mem [CAPACITY];

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [63:0]    next_order_q;
	entry_t         root_q;
	entry_t         work_q;       // item being placed: new push or moved last leaf
	logic [AW-1:0]  pos_q;        // current hole
	entry_t         pick_q;       // winning child
	logic [AW-1:0]  pick_idx_q;
	entry_t         rd_a_q;
	entry_t         rd_b_q;
	logic           rd_a_root_q;  // port a read targeted the root
	logic           res_ok_q;
	entry_t         res_pop_q;
	logic           m_tvalid_q;
	logic [199:0]   m_tdata_q;
	logic [1:0]     m_tuser_q;

	// request fields
	logic   in_acc;
	logic   in_op;
	entry_t in_entry;

	assign in_acc         = s_tvalid && s_tready;
	assign in_op          = s_tuser[0];
	assign in_entry.id    = s_tdata[31:0];
	assign in_entry.pri   = s_tdata[63:32];
	assign in_entry.ord   = next_order_q;

	assign s_tready = state_q == ST_IDLE;

	// index arithmetic
	logic [AW-1:0] push_pos;
	logic [AW-1:0] push_par;
	logic [AW-1:0] pos_par;
	logic [AW-1:0] last_idx;
	logic [CW-1:0] count_dec;
	logic [AW-1:0] child_base;
	logic [XW-1:0] child_l;
	logic [XW-1:0] child_r;
	logic [XW-1:0] count_x;
	logic          l_ok;
	logic          r_ok;
	logic          full;

	assign full      = count_q == CW'(CAPACITY);
	assign push_pos  = count_q[AW-1:0];
	assign push_par  = (push_pos - AW'(1)) >> 1;
	assign pos_par   = (pos_q - AW'(1)) >> 1;
	assign count_dec = count_q - CW'(1);
	assign last_idx  = count_dec[AW-1:0];

	always_comb begin
		unique case (state_q)
			ST_DN_LOAD: child_base = '0;
			ST_DN_CMP:  child_base = pick_idx_q;
			default:    child_base = pos_q;
		endcase
	end

	assign child_l = {1'b0, child_base, 1'b1};
	assign child_r = child_l + XW'(1);
	assign count_x = XW'(count_q);
	assign l_ok    = child_l < count_x;
	assign r_ok    = child_r < count_x;

	// shared compare unit, operands chosen by the sequencer
	entry_t cmp_a;
	entry_t cmp_b;
	entry_t rd_a_val;
	logic   a_first;

	assign rd_a_val = rd_a_root_q ? root_q : rd_a_q;

	always_comb begin
		unique case (state_q)
			ST_UP: begin
				cmp_a = work_q;
				cmp_b = rd_a_val;
			end
			ST_DN_CMP: begin
				cmp_a = pick_q;
				cmp_b = work_q;
			end
			default: begin
				cmp_a = rd_b_q;
				cmp_b = rd_a_val;
			end
		endcase
	end

	smhpq_cmp u_cmp (
		.a       (cmp_a),
		.b       (cmp_b),
		.a_first (a_first)
	);

	// memory port control
	logic          rd_en;
	logic [AW-1:0] rd_a_addr;
	logic [AW-1:0] rd_b_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          root_we;
	entry_t        root_d;
	logic          hole_we;
	entry_t        hole_data;

	always_comb begin
		rd_en     = 1'b0;
		rd_a_addr = child_l[AW-1:0];
		rd_b_addr = child_r[AW-1:0];
		hole_we   = 1'b0;
		hole_data = work_q;
		root_we   = 1'b0;
		root_d    = in_entry;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_op == OP_PUSH) begin
						// place into empty queue or start climbing from the new leaf
						if (!full && count_q == '0) begin
							root_we = 1'b1;
						end else if (!full) begin
							rd_en     = 1'b1;
							rd_a_addr = push_par;
						end
					end else if (count_q > CW'(1)) begin
						// fetch the last leaf
						rd_en     = 1'b1;
						rd_a_addr = last_idx;
					end
				end
			end
			ST_UP: begin
				hole_we = 1'b1;
				if (a_first) begin
					// parent moves down into the hole
					hole_data = rd_a_val;
					if (pos_par == '0) begin
						root_we = 1'b1;
						root_d  = work_q;
					end else begin
						rd_en     = 1'b1;
						rd_a_addr = (pos_par - AW'(1)) >> 1;
					end
				end
			end
			ST_DN_LOAD: begin
				rd_en = 1'b1;
			end
			ST_DN_PICK: begin
				hole_we = !l_ok;
			end
			ST_DN_CMP: begin
				hole_we = 1'b1;
				if (a_first) begin
					hole_data = pick_q;
					rd_en     = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// a hole at the root goes to the root register
		wr_en   = hole_we && pos_q != '0;
		wr_addr = pos_q;
		wr_data = hole_data;
		if (hole_we && pos_q == '0) begin
			root_we = 1'b1;
			root_d  = hole_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (root_we) begin
			root_q <= root_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				work_q <= in_entry;
				pos_q  <= push_pos;
			end
			ST_UP: begin
				pos_q <= pos_par;
			end
			ST_DN_LOAD: begin
				work_q <= rd_a_q;
				pos_q  <= '0;
			end
			ST_DN_PICK: begin
				if (r_ok && a_first) begin
					pick_q     <= rd_b_q;
					pick_idx_q <= child_r[AW-1:0];
				end else begin
					pick_q     <= rd_a_val;
					pick_idx_q <= child_l[AW-1:0];
				end
			end
			ST_DN_CMP: begin
				pos_q <= pick_idx_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			next_order_q <= '0;
			rd_a_root_q  <= 1'b0;
			res_ok_q     <= 1'b0;
			res_pop_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			// while in ST_FIN the result register is reloaded below instead
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_a_root_q <= rd_a_addr == '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_op == OP_PUSH && !full) begin
							res_ok_q     <= 1'b1;
							res_pop_q    <= '0;
							count_q      <= count_q + CW'(1);
							next_order_q <= next_order_q + 64'd1;
							state_q      <= (count_q != '0) ? ST_UP : ST_FIN;
						end else if (in_op == OP_POP && count_q != '0) begin
							res_ok_q  <= 1'b1;
							res_pop_q <= root_q;
							count_q   <= count_dec;
							state_q   <= (count_q > CW'(1)) ? ST_DN_LOAD : ST_FIN;
						end else begin
							// push when full or pop when empty
							res_ok_q  <= 1'b0;
							res_pop_q <= '0;
							state_q   <= ST_FIN;
						end
					end
				end
				ST_UP: begin
					if (!a_first || pos_par == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_DN_LOAD: begin
					state_q <= ST_DN_PICK;
				end
				ST_DN_PICK: begin
					state_q <= l_ok ? ST_DN_CMP : ST_FIN;
				end
				ST_DN_CMP: begin
					state_q <= a_first ? ST_DN_PICK : ST_FIN;
				end
				ST_FIN: begin
					// result waits until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= {count_q != '0, res_ok_q};
						m_tdata_q  <= {8'(count_q),
							(count_q != '0) ? root_q.pri : 32'd0,
							(count_q != '0) ? root_q.id : 32'd0,
							res_pop_q.ord, res_pop_q.pri, res_pop_q.id};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/smhpq_chk.sv =====
// ----------------------------------------------------------------------------
// smhpq_chk
// port-level checks of the stable min-heap priority queue
// ----------------------------------------------------------------------------
`include "stable_min_heap_priority_queue_top_assert.svh"

module smhpq_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [199:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// a stalled result stays offered
	`SMHPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// one request at a time: the queue is busy right after taking one
	`SMHPQ_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// a failed request, push or pop, reports no removed task
	`SMHPQ_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata[127:0] == 128'd0, "popped fields set on failure")

	// an empty queue shows a zero head
	`SMHPQ_ASSERT_NOW(a_empty_head, m_tvalid && !m_tuser[1], m_tdata[191:128] == 64'd0, "head fields set while empty")

endmodule

bind stable_min_heap_priority_queue_top smhpq_chk u_smhpq_chk (.*);
